### hdl/svoice_pkg.sv
// svoice_pkg: word types, function codes and register constants for the voice allocator.
// No dependencies; imported by sound_voice_allocator.
package svoice_pkg;

  localparam int unsigned CHANNELS_DEF = 8;
  localparam int unsigned CFG_W        = 4;
  localparam logic [CFG_W-1:0] ACTIVE_RST = 4'd8;

  localparam logic [1:0] FUNC_START   = 2'd0;
  localparam logic [1:0] FUNC_STOP    = 2'd1;
  localparam logic [1:0] FUNC_RELEASE = 2'd2;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] emitter;
    logic [7:0]  priority_req;
    logic [2:0]  channel;
  } svoice_in_t;

  typedef struct packed {
    logic       granted;
    logic [2:0] granted_channel;
    logic       stopped_valid;
    logic [2:0] stopped_channel;
  } svoice_out_t;

endpackage

### hdl/sound_voice_allocator.sv
// sound_voice_allocator: channel allocation with same-emitter reuse and priority eviction.
// Depends on svoice_pkg (word structs, function codes, config reset value).
//
//  channel  ports                         payload        notes
//  in       in_valid / in_ready           in_data        one request word
//  out      out_valid / out_ready         out_data       one result word per request
//  cfg      cfg_valid / cfg_ready         cfg_data       active channel count
//
// Start and stop scan n channels, n the active channel count: one channel's
// emitter and priority are read from the channel memory and checked by the single
// compare stage per cycle, then drain and final follow. Release, unused codes and a
// zero-count scan skip to final. in_ready returns the cycle after the result is loaded.
// Reset (synchronous, rst_n low) frees every channel and sets the count to 8.
// The result sits in an output register; a stalled output holds the finished
// result in the final state, and no new word is taken until the block is idle.
module sound_voice_allocator
  import svoice_pkg::*;
#(
  parameter int unsigned CHANNELS = CHANNELS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  svoice_in_t         in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output svoice_out_t        out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CFG_W-1:0]   cfg_data
);

  localparam int unsigned CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned NW = $clog2(CHANNELS + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_FIN   = 2'd3;

  logic [1:0]          state_r, state_nxt;
  logic [CFG_W-1:0]    active_r;
  svoice_in_t          req_r;
  logic [CW-1:0]       idx_r;
  logic                cmp_v_r;
  logic [CW-1:0]       cmp_idx_r;
  logic [15:0]         rd_emit_r;
  logic [7:0]          rd_pri_r;
  logic [CHANNELS-1:0] busy_r, busy_nxt;

  logic                match_f_r, free_f_r, pri_f_r;
  logic [CW-1:0]       match_i_r, free_i_r, pri_i_r;

  logic                out_valid_r;
  svoice_out_t         out_data_r;

  logic [15:0]         emit_mem [CHANNELS];
  logic [7:0]          pri_mem  [CHANNELS];

  logic [NW-1:0]       n_lim;
  logic                accept, can_load, finish, mem_we, scan_last;
  logic                grant_ok, stop_ok, ch_ok, cmp_busy;
  logic [CW-1:0]       grant_idx, stop_idx, ch_idx;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign can_load  = !out_valid_r || out_ready;
  assign finish    = (state_r == ST_FIN) && can_load;

  assign n_lim     = (int'(active_r) > int'(CHANNELS)) ? NW'(CHANNELS) : NW'(active_r);
  assign scan_last = (NW'(idx_r) + NW'(1)) == n_lim;
  assign cmp_busy  = busy_r[cmp_idx_r];

  assign ch_ok  = int'(req_r.channel) < int'(CHANNELS);
  assign ch_idx = CW'(req_r.channel);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if ((in_data.func == FUNC_START || in_data.func == FUNC_STOP) && n_lim != '0) begin
            state_nxt = ST_SCAN;
          end else begin
            state_nxt = ST_FIN;
          end
        end
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: state_nxt = ST_FIN;
      ST_FIN: begin
        if (can_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // decision from the scan flags
  always_comb begin
    grant_ok  = 1'b0;
    grant_idx = '0;
    stop_ok   = 1'b0;
    stop_idx  = '0;
    case (req_r.func)
      FUNC_START: begin
        if (match_f_r) begin
          // freeing the match leaves a free channel no higher than it
          stop_ok   = 1'b1;
          stop_idx  = match_i_r;
          grant_ok  = 1'b1;
          grant_idx = (free_f_r && free_i_r < match_i_r) ? free_i_r : match_i_r;
        end else if (free_f_r) begin
          grant_ok  = 1'b1;
          grant_idx = free_i_r;
        end else if (pri_f_r) begin
          stop_ok   = 1'b1;
          stop_idx  = pri_i_r;
          grant_ok  = 1'b1;
          grant_idx = pri_i_r;
        end
      end
      FUNC_STOP: begin
        stop_ok  = match_f_r;
        stop_idx = match_i_r;
      end
      FUNC_RELEASE: begin
        stop_ok  = ch_ok && busy_r[ch_idx];
        stop_idx = ch_idx;
      end
      default: ;
    endcase
  end

  always_comb begin
    busy_nxt = busy_r;
    if (stop_ok) begin
      busy_nxt[stop_idx] = 1'b0;
    end
    if (grant_ok) begin
      busy_nxt[grant_idx] = 1'b1;
    end
  end

  assign mem_we = finish && grant_ok;

  // channel memory: one read address per cycle, registered data
  always_ff @(posedge clk) begin
    if (mem_we) begin
      emit_mem[grant_idx] <= req_r.emitter;
      pri_mem[grant_idx]  <= req_r.priority_req;
    end
    rd_emit_r <= emit_mem[idx_r];
    rd_pri_r  <= pri_mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      active_r    <= ACTIVE_RST;
      busy_r      <= '0;
      out_valid_r <= 1'b0;
      cmp_v_r     <= 1'b0;
      idx_r       <= '0;
      match_f_r   <= 1'b0;
      free_f_r    <= 1'b0;
      pri_f_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        active_r <= cfg_data;
      end
      if (finish) begin
        out_valid_r <= 1'b1;
        busy_r      <= busy_nxt;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end

      cmp_v_r <= (state_r == ST_SCAN);
      if (accept) begin
        idx_r     <= '0;
        match_f_r <= 1'b0;
        free_f_r  <= 1'b0;
        pri_f_r   <= 1'b0;
      end else if (state_r == ST_SCAN) begin
        idx_r <= idx_r + CW'(1);
      end

      // compare stage: first hit of each kind wins
      if (cmp_v_r) begin
        if (cmp_busy && rd_emit_r == req_r.emitter && !match_f_r) begin
          match_f_r <= 1'b1;
        end
        if (!cmp_busy && !free_f_r) begin
          free_f_r <= 1'b1;
        end
        if (cmp_busy && rd_pri_r >= req_r.priority_req && !pri_f_r) begin
          pri_f_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_data;
    end
    cmp_idx_r <= idx_r;
    if (cmp_v_r) begin
      if (cmp_busy && rd_emit_r == req_r.emitter && !match_f_r) begin
        match_i_r <= cmp_idx_r;
      end
      if (!cmp_busy && !free_f_r) begin
        free_i_r <= cmp_idx_r;
      end
      if (cmp_busy && rd_pri_r >= req_r.priority_req && !pri_f_r) begin
        pri_i_r <= cmp_idx_r;
      end
    end
    if (finish) begin
      out_data_r.granted         <= grant_ok;
      out_data_r.granted_channel <= grant_ok ? 3'(grant_idx) : 3'd0;
      out_data_r.stopped_valid   <= stop_ok;
      out_data_r.stopped_channel <= stop_ok ? 3'(stop_idx) : 3'd0;
    end
  end

  // checks
  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN |-> NW'(idx_r) < n_lim)
    else $error("scan index past active channel count");

  a_grant_marks_busy: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |=> busy_r[$past(grant_idx)])
    else $error("granted channel not marked busy");

  a_drain_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DRAIN |-> cmp_v_r && !in_ready)
    else $error("drain without a compare in flight");

endmodule
